>>> sv/pmtlb_pkg.sv
// package for the page map tlb translator
// shared constants, types and command structs; no dependencies
`default_nettype none
package pmtlb_pkg;
   localparam int PAGE_INDEX_BITS = 20;
   localparam int TLB_SLOTS = 32;
   localparam int MAP_DEPTH = 1 << PAGE_INDEX_BITS;
   localparam int SLOT_BITS = 5;

   typedef logic [PAGE_INDEX_BITS-1:0] page_index_type;

   typedef enum logic [1:0] {
      FUNC_TRANSLATE = 2'd0,
      FUNC_PROBE     = 2'd1,
      FUNC_WRITE     = 2'd2,
      FUNC_NOP       = 2'd3
   } func_type;

   typedef enum logic [3:0] {
      ST_CLEAR_MAP,
      ST_IDLE,
      ST_LOOKUP,
      ST_RESPOND,
      ST_SPAN_SETUP,
      ST_SPAN_WALK,
      ST_WRITE_SLOT
   } state_type;

   // span selector: 0 old even, 1 old odd, 2 new even, 3 new odd
   typedef struct packed {
      logic       load_req;
      logic       clear_step;
      logic       lookup;
      logic       set_zero;
      logic       span_setup;
      logic [1:0] span_sel;
      logic       span_step;
      logic       write_slot;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic span_active;
      logic span_last;
      logic slot_ok;
      logic [1:0] func;
   } status_type;
endpackage
`default_nettype wire

>>> sv/pmtlb_req_if.sv
// request and response channel interfaces
// depends on nothing
`default_nettype none
interface pmtlb_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [31:0] vaddr;
   logic        is_write;
   logic [4:0]  entry_index;
   logic [31:0] entry_lo_even;
   logic [31:0] entry_lo_odd;
   logic [31:0] entry_high;
   logic [31:0] page_size_mask;
   modport source(output valid, func, vaddr, is_write, entry_index, entry_lo_even,
      entry_lo_odd, entry_high, page_size_mask, input ready);
   modport sink(input valid, func, vaddr, is_write, entry_index, entry_lo_even,
      entry_lo_odd, entry_high, page_size_mask, output ready);
endinterface

interface pmtlb_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] paddr;
   logic        refill_miss;
   modport source(output valid, paddr, refill_miss, input ready);
   modport sink(input valid, paddr, refill_miss, output ready);
endinterface
`default_nettype wire

>>> sv/pmtlb_datapath.sv
// datapath: page maps, slot registers, span walker and response register
// depends on pmtlb_pkg
`default_nettype none
module pmtlb_datapath (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire pmtlb_pkg::cmd_type  cmd,
   output pmtlb_pkg::status_type    status,
   input  wire logic [1:0]          req_func,
   input  wire logic [31:0]         req_vaddr,
   input  wire logic                req_is_write,
   input  wire logic [4:0]          req_entry_index,
   input  wire logic [31:0]         req_entry_lo_even,
   input  wire logic [31:0]         req_entry_lo_odd,
   input  wire logic [31:0]         req_entry_high,
   input  wire logic [31:0]         req_page_size_mask,
   output logic [31:0]              rsp_paddr,
   output logic                     rsp_refill_miss
);
   import pmtlb_pkg::*;

   logic [19:0] read_map [MAP_DEPTH];
   logic [19:0] write_map [MAP_DEPTH];
   logic [18:0] slot_pair_ff [TLB_SLOTS];
   logic [11:0] slot_mask_ff [TLB_SLOTS];
   logic [23:0] slot_fe_ff [TLB_SLOTS];
   logic [23:0] slot_fo_ff [TLB_SLOTS];
   logic [3:0]  slot_flags_ff [TLB_SLOTS];

   logic [1:0]  func_ff;
   logic [31:0] vaddr_ff;
   logic        is_write_ff;
   logic [4:0]  idx_ff;
   logic [31:0] lo_even_ff, lo_odd_ff, high_ff, mask_ff;
   logic [PAGE_INDEX_BITS:0] clr_ff;
   logic [19:0] rd_ff, wr_ff;
   logic [31:0] paddr_ff;
   logic        miss_ff;

   logic [31:0] addr_ff, end_ff, phys_ff;
   logic        active_ff, dirty_ff, fill_ff;

   // span decode
   logic [18:0] sp_pair;
   logic [11:0] sp_mask;
   logic [23:0] sp_frame;
   logic [3:0]  sp_flags;
   logic [31:0] sp_len, sp_start_even, sp_end_even, sp_start, sp_end, sp_phys;
   logic        sp_valid, sp_dirty, sp_fill_ok;
   logic [4:0]  slot_sel;
   logic [19:0] new_value;
   logic [31:0] next_addr;
   page_index_type walk_page;

   assign slot_sel = idx_ff;

   always_comb begin
      if (cmd.span_sel[1]) begin
         sp_pair = high_ff[31:13];
         sp_mask = mask_ff[24:13];
         sp_frame = cmd.span_sel[0] ? lo_odd_ff[29:6] : lo_even_ff[29:6];
         sp_flags = {lo_odd_ff[2], lo_odd_ff[1], lo_even_ff[2], lo_even_ff[1]};
      end else begin
         sp_pair = slot_pair_ff[slot_sel];
         sp_mask = slot_mask_ff[slot_sel];
         sp_frame = cmd.span_sel[0] ? slot_fo_ff[slot_sel] : slot_fe_ff[slot_sel];
         sp_flags = slot_flags_ff[slot_sel];
      end
      sp_len = {8'd0, sp_mask, 12'hFFF};
      sp_start_even = {sp_pair, 13'd0};
      sp_end_even = sp_start_even + sp_len;
      sp_start = cmd.span_sel[0] ? sp_end_even + 32'd1 : sp_start_even;
      sp_end = sp_start + sp_len;
      sp_phys = {sp_frame[19:0], 12'd0};
      sp_valid = cmd.span_sel[0] ? sp_flags[2] : sp_flags[0];
      sp_dirty = cmd.span_sel[0] ? sp_flags[3] : sp_flags[1];
      sp_fill_ok = !(sp_start >= 32'h8000_0000 && sp_end < 32'hC000_0000) &&
                   (sp_phys < 32'h2000_0000);
      if (cmd.span_sel[1] == 1'b0) sp_fill_ok = 1'b1;
   end

   // phys + (addr - start) kept as phys base advanced each page
   assign new_value = {1'b1, phys_ff[30:12]};
   assign next_addr = addr_ff + 32'h1000;
   assign walk_page = addr_ff[PAGE_INDEX_BITS+11:12];

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         active_ff <= 1'b0;
         for (int i = 0; i < TLB_SLOTS; i++) begin
            slot_pair_ff[i] <= '0;
            slot_mask_ff[i] <= '0;
            slot_fe_ff[i] <= '0;
            slot_fo_ff[i] <= '0;
            slot_flags_ff[i] <= '0;
         end
      end else begin
         if (cmd.clear_step) clr_ff <= clr_ff + 1'b1;
         if (cmd.span_setup) begin
            active_ff <= sp_valid && sp_fill_ok && (sp_start < sp_end);
         end else if (cmd.span_step && active_ff) begin
            active_ff <= ({1'b0, next_addr} < {1'b0, end_ff}) && (next_addr != 32'd0);
         end
         if (cmd.write_slot) begin
            slot_pair_ff[slot_sel] <= high_ff[31:13];
            slot_mask_ff[slot_sel] <= mask_ff[24:13];
            slot_fe_ff[slot_sel] <= lo_even_ff[29:6];
            slot_fo_ff[slot_sel] <= lo_odd_ff[29:6];
            slot_flags_ff[slot_sel] <= {lo_odd_ff[2], lo_odd_ff[1],
                                        lo_even_ff[2], lo_even_ff[1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         func_ff <= req_func;
         vaddr_ff <= req_vaddr;
         is_write_ff <= req_is_write;
         idx_ff <= req_entry_index;
         lo_even_ff <= req_entry_lo_even;
         lo_odd_ff <= req_entry_lo_odd;
         high_ff <= req_entry_high;
         mask_ff <= req_page_size_mask;
      end
      if (cmd.span_setup) begin
         addr_ff <= sp_start;
         end_ff <= sp_end;
         phys_ff <= sp_phys;
         dirty_ff <= sp_dirty;
         fill_ff <= cmd.span_sel[1];
      end else if (cmd.span_step) begin
         addr_ff <= next_addr;
         phys_ff <= phys_ff + 32'h1000;
      end
   end

   // page map memories, read at the incoming request address
   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         read_map[clr_ff[PAGE_INDEX_BITS-1:0]] <= '0;
         write_map[clr_ff[PAGE_INDEX_BITS-1:0]] <= '0;
      end else if (cmd.span_step && active_ff) begin
         read_map[walk_page] <= fill_ff ? new_value : 20'd0;
         if (dirty_ff) write_map[walk_page] <= fill_ff ? new_value : 20'd0;
      end
      rd_ff <= read_map[req_vaddr[PAGE_INDEX_BITS+11:12]];
      wr_ff <= write_map[req_vaddr[PAGE_INDEX_BITS+11:12]];
   end

   // response register
   always_ff @(posedge clock) begin
      if (cmd.set_zero) begin
         paddr_ff <= '0;
         miss_ff <= 1'b0;
      end else if (cmd.lookup) begin
         if (func_ff == FUNC_TRANSLATE) begin
            if (is_write_ff) begin
               paddr_ff <= (wr_ff == '0) ? 32'd0 : {wr_ff, vaddr_ff[11:0]};
               miss_ff <= (wr_ff == '0);
            end else begin
               paddr_ff <= (rd_ff == '0) ? 32'd0 : {rd_ff, vaddr_ff[11:0]};
               miss_ff <= (rd_ff == '0);
            end
         end else begin
            miss_ff <= 1'b0;
            if (vaddr_ff[31:30] == 2'b10) paddr_ff <= vaddr_ff;
            else paddr_ff <= (rd_ff == '0) ? 32'd0 : {rd_ff, vaddr_ff[11:0]};
         end
      end
   end

   assign rsp_paddr = paddr_ff;
   assign rsp_refill_miss = miss_ff;
   assign status.clear_done = clr_ff[PAGE_INDEX_BITS];
   assign status.span_active = active_ff;
   assign status.span_last = ({1'b0, next_addr} >= {1'b0, end_ff}) || (next_addr == 32'd0);
   assign status.slot_ok = ({1'b0, idx_ff} < (SLOT_BITS+1)'(TLB_SLOTS));
   assign status.func = func_ff;

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      miss_ff |-> paddr_ff == 32'd0) else $error("miss with nonzero address");
   a_clear_stop: assert property (@(posedge clock) disable iff (reset)
      clr_ff[PAGE_INDEX_BITS] |=> clr_ff[PAGE_INDEX_BITS]) else $error("clear counter wrapped");
   a_walk_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.clear_step && cmd.span_step)) else $error("clear and walk together");
endmodule
`default_nettype wire

>>> sv/pmtlb_control.sv
// controller state machine: clearing pass, lookup and span walk sequencing
// depends on pmtlb_pkg
`default_nettype none
module pmtlb_control (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output pmtlb_pkg::cmd_type         cmd,
   input  wire pmtlb_pkg::status_type status
);
   import pmtlb_pkg::*;

   state_type state_ff, state_in;
   logic [1:0] sel_ff, sel_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR_MAP;
         sel_ff <= '0;
      end else begin
         state_ff <= state_in;
         sel_ff <= sel_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      sel_in = sel_ff;
      cmd = '0;
      cmd.span_sel = sel_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_CLEAR_MAP: begin
            if (status.clear_done) state_in = ST_IDLE;
            else cmd.clear_step = 1'b1;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (status.func == FUNC_TRANSLATE || status.func == FUNC_PROBE) begin
               cmd.lookup = 1'b1;
               state_in = ST_RESPOND;
            end else begin
               cmd.set_zero = 1'b1;
               if (status.func == FUNC_WRITE && status.slot_ok) begin
                  sel_in = 2'd0;
                  state_in = ST_SPAN_SETUP;
               end else begin
                  state_in = ST_RESPOND;
               end
            end
         end
         ST_SPAN_SETUP: begin
            cmd.span_setup = 1'b1;
            state_in = ST_SPAN_WALK;
         end
         ST_SPAN_WALK: begin
            cmd.span_step = 1'b1;
            if (!status.span_active || status.span_last) begin
               if (sel_ff == 2'd1) begin
                  state_in = ST_WRITE_SLOT;
               end else if (sel_ff == 2'd3) begin
                  state_in = ST_RESPOND;
               end else begin
                  sel_in = sel_ff + 2'd1;
                  state_in = ST_SPAN_SETUP;
               end
            end
         end
         ST_WRITE_SLOT: begin
            cmd.write_slot = 1'b1;
            sel_in = 2'd2;
            state_in = ST_SPAN_SETUP;
         end
         ST_RESPOND: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid) else $error("ready while response pending");
   a_load_next: assert property (@(posedge clock) disable iff (reset)
      cmd.load_req |=> state_ff == ST_LOOKUP) else $error("bad load sequencing");
   a_slot_after_old: assert property (@(posedge clock) disable iff (reset)
      cmd.write_slot |-> sel_ff == 2'd1) else $error("slot written out of order");
endmodule
`default_nettype wire

>>> sv/page_map_tlb_translator.sv
// top level of the page map tlb translator
// depends on pmtlb_pkg, pmtlb_req_if, pmtlb_control, pmtlb_datapath
//
// req channel carries translate, probe and write-entry requests; rsp returns
// one paddr / refill_miss pair for every request, in order.
// translate and probe: the page maps are read at the accepting edge, the
// response register loads at the next edge, in the lookup state, and rsp
// is valid in the respond state that follows, until it is taken.
// a write-entry request walks the old even and odd spans (clearing) and the
// new spans (filling), one page per cycle through each page map's single
// write port; each span has a setup and a walk state, the slot is written
// between old and new spans, and an empty or invalid span ends at once.
// one request is in flight at a time; req ready is low until the response
// has been taken, so a stalled receiver holds rsp and blocks new requests.
// after reset a clearing pass sweeps both page maps, one entry per cycle,
// with req ready low; all slots reset to invalid.
`default_nettype none
module page_map_tlb_translator (
   input wire logic clock,
   input wire logic reset,
   pmtlb_req_if.sink   req,
   pmtlb_rsp_if.source rsp
);
   import pmtlb_pkg::*;

   cmd_type    cmd;
   status_type status;

   pmtlb_control u_control (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .cmd(cmd), .status(status)
   );

   pmtlb_datapath u_datapath (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .req_func(req.func), .req_vaddr(req.vaddr), .req_is_write(req.is_write),
      .req_entry_index(req.entry_index), .req_entry_lo_even(req.entry_lo_even),
      .req_entry_lo_odd(req.entry_lo_odd), .req_entry_high(req.entry_high),
      .req_page_size_mask(req.page_size_mask),
      .rsp_paddr(rsp.paddr), .rsp_refill_miss(rsp.refill_miss)
   );
endmodule
`default_nettype wire
